/* rtl/core/dses_pkg.sv */
// Shared types, register codes and a saturation helper for the dual encoder speed estimator.
`timescale 1ns / 1ps

package dses_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int STEP_OUT_BITS      = 16;
   localparam int WORD_BITS          = 32;
   localparam int SCALE_BITS         = 16;
   localparam int MUL_A_BITS         = WORD_BITS + 1;
   localparam int PROD_BITS          = MUL_A_BITS + SCALE_BITS + 1;
   localparam int RSP_DATA_BITS      = 2 * STEP_OUT_BITS + 6 * WORD_BITS;
   localparam int CSR_ADDR_BITS      = 4;
   localparam int CSR_DATA_BITS      = 32;
   localparam int EMA_SHIFT          = 16;

   localparam logic [SCALE_BITS-1:0] SPEED_SCALE_RESET  = 16'd256;
   localparam logic [SCALE_BITS-1:0] FILTER_ALPHA_RESET = 16'd16384;

   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef enum logic [1:0] {
      CSR_LEFT_INVERT  = 2'd0,
      CSR_RIGHT_INVERT = 2'd1,
      CSR_SPEED_SCALE  = 2'd2,
      CSR_FILTER_ALPHA = 2'd3
   } dses_csr_addr_type;

   typedef struct packed {
      logic                  left_invert;
      logic                  right_invert;
      logic [SCALE_BITS-1:0] speed_scale;
      logic [SCALE_BITS-1:0] filter_alpha;
   } dses_cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEFT_RAW,
      ST_RIGHT_RAW,
      ST_LEFT_EMA,
      ST_RIGHT_EMA,
      ST_RIGHT_UPDATE,
      ST_DONE
   } dses_state_type;

   typedef enum logic [1:0] {
      MUL_STEP_LEFT,
      MUL_STEP_RIGHT,
      MUL_EMA_LEFT,
      MUL_EMA_RIGHT
   } dses_mul_sel_type;

   typedef struct packed {
      logic             capture;
      logic             mul_go;
      dses_mul_sel_type mul_sel;
      logic             wr_raw_left;
      logic             wr_raw_right;
      logic             wr_filt_left;
      logic             wr_filt_right;
      logic             publish;
   } dses_cmd_type;

   function automatic logic signed [WORD_BITS-1:0] sat_s32(input logic signed [63:0] v);
      logic signed [WORD_BITS-1:0] r;
      if (v > S32_MAX) begin
         r = WORD_BITS'(S32_MAX);
      end else if (v < S32_MIN) begin
         r = WORD_BITS'(S32_MIN);
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/dses_csr.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module dses_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dses_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [dses_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [dses_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output dses_pkg::dses_cfg_type              cfg
);

   dses_pkg::dses_cfg_type      cfg_ff;
   dses_pkg::dses_cfg_type      cfg_in;
   dses_pkg::dses_csr_addr_type addr;
   logic                        wr_en;

   assign addr       = dses_pkg::dses_csr_addr_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (addr)
            dses_pkg::CSR_LEFT_INVERT:  cfg_in.left_invert  = csr_pwdata[0];
            dses_pkg::CSR_RIGHT_INVERT: cfg_in.right_invert = csr_pwdata[0];
            dses_pkg::CSR_SPEED_SCALE:  cfg_in.speed_scale  =
                                           csr_pwdata[dses_pkg::SCALE_BITS-1:0];
            dses_pkg::CSR_FILTER_ALPHA: cfg_in.filter_alpha =
                                           csr_pwdata[dses_pkg::SCALE_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (addr)
         dses_pkg::CSR_LEFT_INVERT:
            csr_prdata = dses_pkg::CSR_DATA_BITS'(cfg_ff.left_invert);
         dses_pkg::CSR_RIGHT_INVERT:
            csr_prdata = dses_pkg::CSR_DATA_BITS'(cfg_ff.right_invert);
         dses_pkg::CSR_SPEED_SCALE:
            csr_prdata = dses_pkg::CSR_DATA_BITS'(cfg_ff.speed_scale);
         dses_pkg::CSR_FILTER_ALPHA:
            csr_prdata = dses_pkg::CSR_DATA_BITS'(cfg_ff.filter_alpha);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_invert  <= 1'b0;
         cfg_ff.right_invert <= 1'b0;
         cfg_ff.speed_scale  <= dses_pkg::SPEED_SCALE_RESET;
         cfg_ff.filter_alpha <= dses_pkg::FILTER_ALPHA_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/dses_ctrl.sv */
// Sequencing state machine: steps the shared multiplier through both wheels.
`timescale 1ns / 1ps

module dses_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   out_free,
   output dses_pkg::dses_cmd_type cmd
);

   dses_pkg::dses_state_type state_ff;
   dses_pkg::dses_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dses_pkg::ST_IDLE:         if (req_tvalid) state_in = dses_pkg::ST_LEFT_RAW;
         dses_pkg::ST_LEFT_RAW:     state_in = dses_pkg::ST_RIGHT_RAW;
         dses_pkg::ST_RIGHT_RAW:    state_in = dses_pkg::ST_LEFT_EMA;
         dses_pkg::ST_LEFT_EMA:     state_in = dses_pkg::ST_RIGHT_EMA;
         dses_pkg::ST_RIGHT_EMA:    state_in = dses_pkg::ST_RIGHT_UPDATE;
         dses_pkg::ST_RIGHT_UPDATE: state_in = dses_pkg::ST_DONE;
         dses_pkg::ST_DONE:         if (out_free) state_in = dses_pkg::ST_IDLE;
         default:                   state_in = dses_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         dses_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         dses_pkg::ST_LEFT_RAW: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = dses_pkg::MUL_STEP_LEFT;
         end
         dses_pkg::ST_RIGHT_RAW: begin
            cmd.mul_go      = 1'b1;
            cmd.mul_sel     = dses_pkg::MUL_STEP_RIGHT;
            cmd.wr_raw_left = 1'b1;
         end
         dses_pkg::ST_LEFT_EMA: begin
            cmd.mul_go       = 1'b1;
            cmd.mul_sel      = dses_pkg::MUL_EMA_LEFT;
            cmd.wr_raw_right = 1'b1;
         end
         dses_pkg::ST_RIGHT_EMA: begin
            cmd.mul_go       = 1'b1;
            cmd.mul_sel      = dses_pkg::MUL_EMA_RIGHT;
            cmd.wr_filt_left = 1'b1;
         end
         dses_pkg::ST_RIGHT_UPDATE: begin
            cmd.wr_filt_right = 1'b1;
         end
         dses_pkg::ST_DONE: begin
            cmd.publish = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dses_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/dses_datapath.sv */
// Wheel state, shared multiplier, filter update and result register.
`timescale 1ns / 1ps

module dses_datapath #(
   parameter int COUNT_BITS = dses_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dses_pkg::dses_cmd_type               cmd,
   input  dses_pkg::dses_cfg_type               cfg,
   input  logic [COUNT_BITS-1:0]                left_count,
   input  logic [COUNT_BITS-1:0]                right_count,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [dses_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 out_free
);

   localparam int W  = dses_pkg::WORD_BITS;
   localparam int AW = dses_pkg::MUL_A_BITS;
   localparam int PW = dses_pkg::PROD_BITS;
   localparam int SW = dses_pkg::STEP_OUT_BITS;

   logic [COUNT_BITS-1:0]        left_prev_ff, right_prev_ff;
   logic signed [COUNT_BITS-1:0] left_step_ff, right_step_ff;
   logic signed [COUNT_BITS-1:0] left_step_in, right_step_in;
   logic [COUNT_BITS-1:0]        left_diff, right_diff;
   logic [W-1:0]                 left_acc_ff, right_acc_ff;
   logic [W-1:0]                 left_acc_in, right_acc_in;
   logic signed [W-1:0]          left_raw_ff, right_raw_ff;
   logic signed [W-1:0]          left_filt_ff, right_filt_ff;
   logic signed [W-1:0]          raw_sat;
   logic signed [W-1:0]          filt_base;
   logic signed [W-1:0]          filt_next;
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic signed [AW-1:0]         mul_a;
   logic [dses_pkg::SCALE_BITS-1:0] mul_b;
   logic signed [PW:0]           round_sum;
   logic signed [PW-dses_pkg::EMA_SHIFT:0] ema_inc;
   logic signed [PW-dses_pkg::EMA_SHIFT+1:0] filt_sum;
   logic [W-1:0]                 left_step_wide, right_step_wide;
   logic                         rsp_tvalid_ff;
   logic [dses_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;

   // wrapped difference, optional negate (most negative wraps to itself)
   assign left_diff     = left_count - left_prev_ff;
   assign right_diff    = right_count - right_prev_ff;
   assign left_step_in  = cfg.left_invert  ? COUNT_BITS'(-left_diff)  : left_diff;
   assign right_step_in = cfg.right_invert ? COUNT_BITS'(-right_diff) : right_diff;
   assign left_acc_in   = left_acc_ff  + W'(left_step_in);
   assign right_acc_in  = right_acc_ff + W'(right_step_in);

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         dses_pkg::MUL_STEP_LEFT: begin
            mul_a = AW'(left_step_ff);
            mul_b = cfg.speed_scale;
         end
         dses_pkg::MUL_STEP_RIGHT: begin
            mul_a = AW'(right_step_ff);
            mul_b = cfg.speed_scale;
         end
         dses_pkg::MUL_EMA_LEFT: begin
            mul_a = AW'(left_raw_ff) - AW'(left_filt_ff);
            mul_b = cfg.filter_alpha;
         end
         dses_pkg::MUL_EMA_RIGHT: begin
            mul_a = AW'(right_raw_ff) - AW'(right_filt_ff);
            mul_b = cfg.filter_alpha;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * $signed({1'b0, mul_b});

   // raw speed saturates; filter adds the rounded increment and saturates
   assign raw_sat   = dses_pkg::sat_s32(64'(prod_ff));
   assign round_sum = (PW+1)'(prod_ff) + (PW+1)'(1 <<< (dses_pkg::EMA_SHIFT - 1));
   assign ema_inc   = (PW-dses_pkg::EMA_SHIFT+1)'(round_sum >>> dses_pkg::EMA_SHIFT);
   assign filt_base = cmd.wr_filt_left ? left_filt_ff : right_filt_ff;
   assign filt_sum  = (PW-dses_pkg::EMA_SHIFT+2)'(filt_base)
                      + (PW-dses_pkg::EMA_SHIFT+2)'(ema_inc);
   assign filt_next = dses_pkg::sat_s32(64'(filt_sum));

   assign left_step_wide  = W'(left_step_ff);
   assign right_step_wide = W'(right_step_ff);

   assign out_free   = ~rsp_tvalid_ff | rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_prev_ff  <= '0;
         right_prev_ff <= '0;
         left_acc_ff   <= '0;
         right_acc_ff  <= '0;
         left_filt_ff  <= '0;
         right_filt_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            left_prev_ff  <= left_count;
            right_prev_ff <= right_count;
            left_acc_ff   <= left_acc_in;
            right_acc_ff  <= right_acc_in;
         end
         if (cmd.wr_filt_left) begin
            left_filt_ff <= filt_next;
         end
         if (cmd.wr_filt_right) begin
            right_filt_ff <= filt_next;
         end
         if (cmd.publish) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_step_ff  <= left_step_in;
         right_step_ff <= right_step_in;
      end
      if (cmd.mul_go) begin
         prod_ff <= prod_in;
      end
      if (cmd.wr_raw_left) begin
         left_raw_ff <= raw_sat;
      end
      if (cmd.wr_raw_right) begin
         right_raw_ff <= raw_sat;
      end
      if (cmd.publish) begin
         rsp_data_ff <= {right_filt_ff, left_filt_ff, right_raw_ff, left_raw_ff,
                         right_acc_ff, left_acc_ff,
                         right_step_wide[SW-1:0], left_step_wide[SW-1:0]};
      end
   end

endmodule

/* rtl/core/dual_encoder_speed_estimator.sv */
// Top level of the dual encoder speed estimator.
`timescale 1ns / 1ps

// Each request transaction carries the raw counts of the left and right wheel
// encoders for one sample tick; the block returns one response transaction per
// request with, per wheel, the signed count step (optionally negated), the
// wrapping 32-bit running total, the raw speed in signed Q23.8 mm/s (step times
// the Q8.8 speed_scale register, saturated) and the speed after an exponential
// moving average with the Q0.16 filter_alpha register (round to nearest, ties
// up, saturated to 32 bits). Each tick runs through a capture step, four passes
// through the single shared 33x17 multiplier (two speed products, then two
// filter products), a filter update step and a step that loads the response
// register; that load waits while an earlier response is still untaken, and
// requests are not accepted before the load. The response holds until taken;
// a new request can be accepted while it waits.
// Registers sit at byte addresses 0 (left_invert), 4 (right_invert),
// 8 (speed_scale) and 12 (filter_alpha); write them only while the block is idle.
module dual_encoder_speed_estimator #(
   parameter int COUNT_BITS = dses_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: left_count [COUNT_BITS-1:0], right_count above it, zero padded
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((2*COUNT_BITS+7)/8)*8-1:0]  req_tdata,
   // response, lowest bit up: left_step, right_step (16 each), left_sum,
   // right_sum, left_raw_speed, right_raw_speed, left_smooth_speed,
   // right_smooth_speed (32 each)
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dses_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dses_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dses_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dses_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   dses_pkg::dses_cfg_type cfg;
   dses_pkg::dses_cmd_type cmd;
   logic                   out_free;

   // register file
   dses_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: accepts in idle, walks the multiplier schedule, then publishes
   dses_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   // datapath: per-wheel state plus the shared multiplier and response register
   dses_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .left_count  (req_tdata[COUNT_BITS-1:0]),
      .right_count (req_tdata[2*COUNT_BITS-1:COUNT_BITS]),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .out_free    (out_free)
   );

endmodule

/* rtl/core/dses_checker.sv */
// Port-level assertions for the dual encoder speed estimator, bound to the top level.
`timescale 1ns / 1ps

module dses_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [dses_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   // requests accepted whose response has not yet been taken
   always_comb begin
      case ({req_fire, rsp_fire})
         2'b10:   pending_in = pending_ff + 2'd1;
         2'b01:   pending_in = pending_ff - 2'd1;
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response valid dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response data changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted back to back");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("response without an outstanding request");

endmodule

bind dual_encoder_speed_estimator dses_checker u_dses_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
